// ===== rtl/lmfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lmfl_pkg;

  localparam int LINE_BYTES        = 16;
  localparam int LINE_W            = LINE_BYTES * 8;
  localparam int ADDR_IN_W         = 16;
  localparam int MEM_BYTES_DEFAULT = 65536;
  localparam logic [7:0] LATENCY_RESET = 8'd8;

  // Load sizes; any code above LD_TRIPLE loads four bytes.
  localparam logic [2:0] LD_NONE  = 3'd0;
  localparam logic [2:0] LD_BYTE  = 3'd1;
  localparam logic [2:0] LD_HALF  = 3'd2;
  localparam logic [2:0] LD_TRIPLE = 3'd3;

  // Per-tick status of the two line ports.
  typedef struct packed {
    logic rd_done;   // read completes this tick
    logic wr_done;   // write lands this tick
    logic rd_busy;   // read port busy after this tick
    logic wr_busy;   // write port busy after this tick
  } port_stat_t;

endpackage
`default_nettype wire

// ===== rtl/line_memory_fixed_latency_ports.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Byte memory with a fixed-latency line read port, a line write port and a
// direct narrow load. Each input transaction is one tick of the memory: line
// requests, write data and the load address/size. Each tick yields exactly one
// output transaction: reply pulse, reply line, port busy flags, load value.
// The configuration channel writes line_latency; write it only while idle.
// Throughput: one transaction per cycle while out_ready is high. A result
// passes through the input stage, then the result stage, with the registered
// read of the line memory; out_valid rises when it enters the result stage.
// A line read launched at the accept edge sees memory before that tick's
// write; the narrow load reads later, when the input stage moves on, and so
// sees it.
// Memory is two banks (even and odd lines) of 128-bit rows, each with one
// write and two read ports, so an unaligned load over two lines reads once per
// bank. MEMORY_BYTES must be a power of two.
// Reset (rst_n, synchronous) clears both ports, the reply buffer and the
// pipeline, and sets line_latency to 8; memory contents are not cleared.
// When out_ready is low the result stage holds, the input stage fills, and
// in_ready drops; nothing advances, so no memory access is lost or repeated.
module line_memory_fixed_latency_ports
  import lmfl_pkg::*;
#(
  parameter int MEMORY_BYTES = MEM_BYTES_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [7:0]           cfg_line_latency,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_read_request,
  input  wire logic [15:0]          in_read_address,
  input  wire logic                 in_write_request,
  input  wire logic [15:0]          in_write_address,
  input  wire logic [63:0]          in_write_line_low,
  input  wire logic [63:0]          in_write_line_high,
  input  wire logic [15:0]          in_load_address,
  input  wire logic [2:0]           in_load_size,
  input  wire logic                 in_load_signed,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_reply_valid,
  output logic [63:0]               out_reply_line_low,
  output logic [63:0]               out_reply_line_high,
  output logic                      out_read_port_busy,
  output logic                      out_write_port_busy,
  output logic signed [31:0]        out_load_value
);

  localparam int ADDR_W = $clog2(MEMORY_BYTES);
  localparam int ROW_W  = ADDR_W - 5;   // row address width per bank: one row per pair of lines

  // Handshake / pipeline control
  logic in_acc, adv1;
  logic v1_r, v2_r;

  assign cfg_ready = 1'b1;
  assign adv1      = v1_r && (!v2_r || out_ready);
  assign in_ready  = !v1_r || adv1;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (adv1) begin
        v1_r <= 1'b0;
      end
      if (adv1) begin
        v2_r <= 1'b1;
      end else if (out_ready) begin
        v2_r <= 1'b0;
      end
    end
  end

  // Port state machines, stepped once per accepted transaction
  logic [ADDR_IN_W-1:0] rd_line_addr, wr_line_addr;
  logic [LINE_W-1:0]    wr_line_data;
  port_stat_t           stat;

  lmfl_ports u_ports (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_line_latency),
    .tick         (in_acc),
    .rd_req       (in_read_request),
    .rd_addr      (in_read_address),
    .wr_req       (in_write_request),
    .wr_addr      (in_write_address),
    .wr_line      ({in_write_line_high, in_write_line_low}),
    .rd_line_addr (rd_line_addr),
    .wr_line_addr (wr_line_addr),
    .wr_line_data (wr_line_data),
    .stat         (stat)
  );

  // Input stage: load request and port status of the accepted tick
  logic [ADDR_W-1:0] ld_addr_r;
  logic [2:0]        ld_size_r;
  logic              ld_sign_r;
  logic              rd_done_r, rd_bank_r, rd_busy_r, wr_busy_r;

  logic [ADDR_W-1:0] rd_a, wr_a;
  assign rd_a = ADDR_W'(rd_line_addr);
  assign wr_a = ADDR_W'(wr_line_addr);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ld_addr_r <= ADDR_W'(in_load_address);
      ld_size_r <= in_load_size;
      ld_sign_r <= in_load_signed;
      rd_done_r <= stat.rd_done;
      rd_bank_r <= rd_a[4];
      rd_busy_r <= stat.rd_busy;
      wr_busy_r <= stat.wr_busy;
    end
  end

  // Line banks. Port A serves the line read at the accept edge, port B the
  // narrow load when the input stage moves on.
  logic [ROW_W-1:0]  rd_row, wr_row, ld_row, ld_row_even;
  logic              we_even, we_odd;
  logic [LINE_W-1:0] qa_even, qa_odd, qb_even, qb_odd;

  assign rd_row      = rd_a[ADDR_W-1:5];
  assign wr_row      = wr_a[ADDR_W-1:5];
  assign ld_row      = ld_addr_r[ADDR_W-1:5];
  // an odd first line continues into the next even line, wrapping at the end
  assign ld_row_even = ld_row + ROW_W'(ld_addr_r[4]);
  assign we_even     = in_acc && stat.wr_done && !wr_a[4];
  assign we_odd      = in_acc && stat.wr_done && wr_a[4];

  lmfl_bank #(.ROW_W(ROW_W)) u_bank_even (
    .clk   (clk),
    .we    (we_even),
    .wa    (wr_row),
    .wd    (wr_line_data),
    .ra_en (in_acc),
    .ra    (rd_row),
    .qa    (qa_even),
    .rb_en (adv1),
    .rb    (ld_row_even),
    .qb    (qb_even)
  );

  lmfl_bank #(.ROW_W(ROW_W)) u_bank_odd (
    .clk   (clk),
    .we    (we_odd),
    .wa    (wr_row),
    .wd    (wr_line_data),
    .ra_en (in_acc),
    .ra    (rd_row),
    .qa    (qa_odd),
    .rb_en (adv1),
    .rb    (ld_row),
    .qb    (qb_odd)
  );

  // Result stage
  logic [LINE_W-1:0] reply_buf_r;
  logic              reply_pulse_r, rd_busy2_r, wr_busy2_r;
  logic [3:0]        ld_off_r;
  logic              ld_odd_r, ld_sign2_r;
  logic [2:0]        ld_size2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_buf_r   <= '0;
      reply_pulse_r <= 1'b0;
      rd_busy2_r    <= 1'b0;
      wr_busy2_r    <= 1'b0;
    end else if (adv1) begin
      reply_pulse_r <= rd_done_r;
      rd_busy2_r    <= rd_busy_r;
      wr_busy2_r    <= wr_busy_r;
      if (rd_done_r) begin
        reply_buf_r <= rd_bank_r ? qa_odd : qa_even;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ld_off_r   <= ld_addr_r[3:0];
      ld_odd_r   <= ld_addr_r[4];
      ld_size2_r <= ld_size_r;
      ld_sign2_r <= ld_sign_r;
    end
  end

  lmfl_load u_load (
    .q_even   (qb_even),
    .q_odd    (qb_odd),
    .offset   (ld_off_r),
    .odd_line (ld_odd_r),
    .size     (ld_size2_r),
    .sign_ext (ld_sign2_r),
    .value    (out_load_value)
  );

  assign out_reply_valid     = reply_pulse_r;
  assign out_reply_line_low  = reply_buf_r[63:0];
  assign out_reply_line_high = reply_buf_r[127:64];
  assign out_read_port_busy  = rd_busy2_r;
  assign out_write_port_busy = wr_busy2_r;

endmodule
`default_nettype wire

// ===== rtl/lmfl_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lmfl_bank
  import lmfl_pkg::*;
#(
  parameter int ROW_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ROW_W-1:0]  wa,
  input  wire logic [LINE_W-1:0] wd,
  input  wire logic              ra_en,
  input  wire logic [ROW_W-1:0]  ra,
  output logic      [LINE_W-1:0] qa,
  input  wire logic              rb_en,
  input  wire logic [ROW_W-1:0]  rb,
  output logic      [LINE_W-1:0] qb
);

  logic [LINE_W-1:0] store_r [2**ROW_W];

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[wa] <= wd;
    end
    if (ra_en) begin
      qa <= store_r[ra];
    end
    if (rb_en) begin
      qb <= store_r[rb];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lmfl_ports.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lmfl_ports
  import lmfl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 tick,
  input  wire logic                 rd_req,
  input  wire logic [ADDR_IN_W-1:0] rd_addr,
  input  wire logic                 wr_req,
  input  wire logic [ADDR_IN_W-1:0] wr_addr,
  input  wire logic [LINE_W-1:0]    wr_line,
  output logic      [ADDR_IN_W-1:0] rd_line_addr,
  output logic      [ADDR_IN_W-1:0] wr_line_addr,
  output logic      [LINE_W-1:0]    wr_line_data,
  output port_stat_t                stat
);

  logic [7:0]           latency_r;
  logic                 rd_pend_r, wr_pend_r;
  logic [7:0]           rd_cnt_r, wr_cnt_r;
  logic [ADDR_IN_W-1:0] rd_addr_r, wr_addr_r;
  logic [LINE_W-1:0]    wr_buf_r;
  logic                 rd_start, wr_start;

  assign rd_start = rd_req && !rd_pend_r;
  assign wr_start = wr_req && !wr_pend_r;

  always_comb begin
    stat.rd_done = rd_pend_r && (rd_cnt_r == 8'd1);
    stat.wr_done = wr_pend_r && (wr_cnt_r == 8'd1);
    stat.rd_busy = (rd_pend_r && !stat.rd_done) || rd_start;
    stat.wr_busy = (wr_pend_r && !stat.wr_done) || wr_start;
  end

  assign rd_line_addr = rd_addr_r;
  assign wr_line_addr = wr_addr_r;
  assign wr_line_data = wr_buf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latency_r <= LATENCY_RESET;
      rd_pend_r <= 1'b0;
      wr_pend_r <= 1'b0;
      rd_cnt_r  <= 8'd0;
      wr_cnt_r  <= 8'd0;
      rd_addr_r <= '0;
      wr_addr_r <= '0;
      wr_buf_r  <= '0;
    end else begin
      if (cfg_we) begin
        latency_r <= cfg_data;
      end
      if (tick) begin
        // a latency of zero wraps the 8-bit count: 256 ticks
        if (stat.rd_done) begin
          rd_pend_r <= 1'b0;
        end else if (rd_pend_r) begin
          rd_cnt_r <= rd_cnt_r - 8'd1;
        end
        if (stat.wr_done) begin
          wr_pend_r <= 1'b0;
        end else if (wr_pend_r) begin
          wr_cnt_r <= wr_cnt_r - 8'd1;
        end
        if (rd_start) begin
          rd_addr_r <= rd_addr;
          rd_cnt_r  <= latency_r;
          rd_pend_r <= 1'b1;
        end
        if (wr_start) begin
          wr_addr_r <= wr_addr;
          wr_cnt_r  <= latency_r;
          wr_buf_r  <= wr_line;
          wr_pend_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lmfl_load.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lmfl_load
  import lmfl_pkg::*;
(
  input  wire logic              [LINE_W-1:0] q_even,
  input  wire logic              [LINE_W-1:0] q_odd,
  input  wire logic              [3:0]        offset,
  input  wire logic                           odd_line,
  input  wire logic              [2:0]        size,
  input  wire logic                           sign_ext,
  output logic signed            [31:0]       value
);

  logic [2*LINE_W-1:0] window;
  logic [31:0]         raw;

  // first line in the low half, the following line above it
  assign window = odd_line ? {q_even, q_odd} : {q_odd, q_even};
  assign raw    = window[{offset, 3'b000} +: 32];

  always_comb begin
    case (size)
      LD_NONE:   value = '0;
      LD_BYTE:   value = {{24{sign_ext & raw[7]}},  raw[7:0]};
      LD_HALF:   value = {{16{sign_ext & raw[15]}}, raw[15:0]};
      LD_TRIPLE: value = {{8{sign_ext & raw[23]}},  raw[23:0]};
      default:   value = raw;
    endcase
  end

endmodule
`default_nettype wire
